/* hw/rtl/c3rb_pkg.sv */
// Shared types, constants and helpers for the 3x3 replicate-border convolution.
// Used by every module under hw/rtl; depends on nothing else.
package c3rb_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DIM_W          = 11;
	localparam int KROW_W         = 48;
	localparam int CFG_IDX_W      = 3;
	localparam int QUEUE_DEPTH    = 4;
	localparam int BANKS          = 4;
	localparam int SUM_W          = 29;
	localparam int PROD_W         = 25;

	typedef logic [31:0] pixel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH  = 3'd0,
		CFG_HEIGHT = 3'd1,
		CFG_FOUR   = 3'd2,
		CFG_KTOP   = 3'd3,
		CFG_KMID   = 3'd4,
		CFG_KBOT   = 3'd5
	} cfg_idx_t;

	localparam logic [DIM_W-1:0]  RST_WIDTH  = 11'd1024;
	localparam logic [DIM_W-1:0]  RST_HEIGHT = 11'd1024;
	localparam logic [KROW_W-1:0] RST_KTOP   = 48'h0;
	localparam logic [KROW_W-1:0] RST_KMID   = 48'h0000_0100_0000;
	localparam logic [KROW_W-1:0] RST_KBOT   = 48'h0;

	typedef struct packed {
		logic [DIM_W-1:0]            image_width;
		logic [DIM_W-1:0]            image_height;
		logic                        four_channels;
		logic [2:0][KROW_W-1:0]      kernel;     // [0] top, [1] mid, [2] bottom
	} cfg_t;

	// one output position: right column and row-0 column of the window, per window row
	typedef struct packed {
		logic [2:0][31:0] col_a;
		logic [2:0][31:0] col_b;
		logic             first;
		logic             frame_end;
		logic             four_ch;
	} job_t;

	function automatic logic [7:0] sat_q8(input logic signed [SUM_W-1:0] s);
		logic [SUM_W-9:0] whole;
		whole = s[SUM_W-1:8];
		if (s <= 0) begin
			return 8'd0;
		end else if (whole > (SUM_W-8)'(255)) begin
			return 8'd255;
		end
		return whole[7:0];
	endfunction

endpackage

/* hw/rtl/conv3x3_replicate_border.sv */
// Streaming 3x3 convolution with replicated borders over RGB or RGBA pixels
// arriving in raster order. Output pixel m leaves once input pixel
// m + width + 1 has arrived, or the whole frame has; send drain items
// (s_tuser = 1) after the last pixel to flush the outputs still owed, one per
// item. One item is taken every clock unless a held job waits on a full queue.
// For the item that releases a result, the line store is read at the accepting
// edge, then the job is written to the queue, the tap products are registered,
// and the sum and clamp go into the output register.
// The line store is four row banks of MAX_WIDTH words; it needs no clearing.
// Write configuration only while the block is idle.
module conv3x3_replicate_border #(
	parameter int MAX_WIDTH  = c3rb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = c3rb_pkg::DEF_MAX_HEIGHT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [c3rb_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [c3rb_pkg::KROW_W-1:0]        cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [31:0]                        s_tdata,  // in_ch0, in_ch1, in_ch2, in_ch3
	input  logic                               s_tuser,  // cmd
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [31:0]                        m_tdata,  // out_ch0, out_ch1, out_ch2, out_ch3
	output logic                               m_tlast   // frame_end
);
	import c3rb_pkg::*;

	cfg_t cfg_q;
	logic push, pop, q_empty, q_full;
	job_t push_job, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= RST_WIDTH;
			cfg_q.image_height  <= RST_HEIGHT;
			cfg_q.four_channels <= 1'b1;
			cfg_q.kernel[0]     <= RST_KTOP;
			cfg_q.kernel[1]     <= RST_KMID;
			cfg_q.kernel[2]     <= RST_KBOT;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_WIDTH:  cfg_q.image_width   <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: cfg_q.image_height  <= cfg_data[DIM_W-1:0];
				CFG_FOUR:   cfg_q.four_channels <= cfg_data[0];
				CFG_KTOP:   cfg_q.kernel[0]     <= cfg_data;
				CFG_KMID:   cfg_q.kernel[1]     <= cfg_data;
				CFG_KBOT:   cfg_q.kernel[2]     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	c3rb_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_cmd  (s_tuser),
		.in_px   (s_tdata),
		.push    (push),
		.push_job(push_job),
		.q_full  (q_full)
	);

	c3rb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.empty   (q_empty),
		.full    (q_full)
	);

	c3rb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data (m_tdata),
		.out_last (m_tlast)
	);

endmodule

/* hw/rtl/c3rb_line_bank.sv */
// One row bank of the line store: one write port, two registered read ports.
// Depends on c3rb_pkg for the pixel type.
module c3rb_line_bank #(
	parameter int DEPTH = c3rb_pkg::DEF_MAX_WIDTH,
	parameter int AW    = 10
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       wa,
	input  c3rb_pkg::pixel_t    wd,
	input  logic                re,
	input  logic [AW-1:0]       ra_a,
	input  logic [AW-1:0]       ra_b,
	output c3rb_pkg::pixel_t    rd_a,
	output c3rb_pkg::pixel_t    rd_b
);
	import c3rb_pkg::*;

	pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		// pass the word being written straight through
		if (re) begin
			rd_a <= (we && wa == ra_a) ? wd : mem[ra_a];
			rd_b <= (we && wa == ra_b) ? wd : mem[ra_b];
		end
	end

endmodule

/* hw/rtl/c3rb_front.sv */
// Input side: position counters, line store banks and the emit decision.
// Depends on c3rb_pkg and c3rb_line_bank; hands one job per output to the queue.
module c3rb_front #(
	parameter int MAX_WIDTH  = c3rb_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = c3rb_pkg::DEF_MAX_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  c3rb_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_cmd,
	input  c3rb_pkg::pixel_t in_px,
	output logic             push,
	output c3rb_pkg::job_t   push_job,
	input  logic             q_full
);
	import c3rb_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 2);
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW = (WW > DIM_W) ? WW : DIM_W;
	localparam int HE = (HW > DIM_W) ? HW : DIM_W;
	localparam int LW = WW + 2;

	logic [EW-1:0] w_raw, w_cl;
	logic [HE-1:0] h_raw, h_cl;
	logic [WW-1:0] w_e;
	logic [HW-1:0] h_e;

	logic [WW-1:0] in_col_q, out_col_q, ic0, ic1, oc0, oc1, ra_a;
	logic [HW-1:0] in_row_q, out_row_q, ir0, ir1, or0, or1;
	logic [LW-1:0] lead_q, ld0, ld1, ld2;
	logic          accept, wr_en, emit, last;
	logic [1:0]    sel_top, sel_bot;

	logic          s1_v_q, s1_emit_s1, s1_first_s1, s1_last_s1, s1_fc_s1;
	logic [2:0][1:0] s1_sel_s1;
	logic          s1_free;

	pixel_t rd_a [BANKS];
	pixel_t rd_b [BANKS];

	always_comb begin
		w_raw = EW'(cfg.image_width);
		if (w_raw == '0) begin
			w_cl = EW'(1);
		end else if (w_raw > EW'(MAX_WIDTH)) begin
			w_cl = EW'(MAX_WIDTH);
		end else begin
			w_cl = w_raw;
		end
		w_e = w_cl[WW-1:0];
		h_raw = HE'(cfg.image_height);
		if (h_raw == '0) begin
			h_cl = HE'(1);
		end else if (h_raw > HE'(MAX_HEIGHT)) begin
			h_cl = HE'(MAX_HEIGHT);
		end else begin
			h_cl = h_raw;
		end
		h_e = h_cl[HW-1:0];
	end

	always_comb begin
		ic0 = in_col_q;
		ir0 = in_row_q;
		oc0 = out_col_q;
		or0 = out_row_q;
		ld0 = lead_q;
		if (ic0 >= w_e) begin
			ic0 = '0;
			ir0 = ir0 + 1'b1;
		end
		if (oc0 >= w_e) begin
			oc0 = '0;
			or0 = or0 + 1'b1;
		end
		if (or0 >= h_e) begin
			ic0 = '0;
			ir0 = '0;
			oc0 = '0;
			or0 = '0;
			ld0 = '0;
		end

		wr_en = !in_cmd && (ir0 < h_e);
		ic1 = ic0;
		ir1 = ir0;
		ld1 = ld0;
		if (wr_en) begin
			ic1 = ic0 + 1'b1;
			ld1 = ld0 + 1'b1;
			if (ic1 >= w_e) begin
				ic1 = '0;
				ir1 = ir0 + 1'b1;
			end
		end

		// lead counts pixels received ahead of the next output
		emit = (ir1 >= h_e) || (ld1 >= LW'(w_e) + LW'(2));
		last = (or0 == h_e - 1'b1) && (oc0 == w_e - 1'b1);

		oc1 = oc0;
		or1 = or0;
		ld2 = ld1;
		if (emit) begin
			ld2 = ld1 - 1'b1;
			oc1 = oc0 + 1'b1;
			if (oc1 >= w_e) begin
				oc1 = '0;
				or1 = or0 + 1'b1;
			end
		end

		ra_a = (oc0 + 1'b1 >= w_e) ? oc0 : oc0 + 1'b1;
		sel_top = (or0 == '0) ? or0[1:0] : or0[1:0] - 2'd1;
		sel_bot = (or0 + 1'b1 >= h_e) ? or0[1:0] : or0[1:0] + 2'd1;
	end

	assign s1_free  = !s1_v_q || !s1_emit_s1 || !q_full;
	assign in_ready = s1_free;
	assign accept   = in_valid && in_ready;
	assign push     = s1_v_q && s1_emit_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lead_q    <= '0;
			s1_v_q    <= 1'b0;
		end else begin
			if (accept) begin
				if (emit && last) begin
					in_col_q  <= '0;
					in_row_q  <= '0;
					out_col_q <= '0;
					out_row_q <= '0;
					lead_q    <= '0;
				end else begin
					in_col_q  <= ic1;
					in_row_q  <= ir1;
					out_col_q <= oc1;
					out_row_q <= or1;
					lead_q    <= ld2;
				end
				s1_v_q <= 1'b1;
			end else if (s1_free) begin
				s1_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_emit_s1  <= emit;
			s1_first_s1 <= (oc0 == '0);
			s1_last_s1  <= last;
			s1_fc_s1    <= cfg.four_channels;
			s1_sel_s1   <= {sel_bot, or0[1:0], sel_top};
		end
	end

	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		c3rb_line_bank #(
			.DEPTH(MAX_WIDTH),
			.AW   (AW)
		) u_bank (
			.clk (clk),
			.we  (accept && wr_en && (ir0[1:0] == 2'(b))),
			.wa  (ic0[AW-1:0]),
			.wd  (in_px),
			.re  (accept),
			.ra_a(ra_a[AW-1:0]),
			.ra_b('0),
			.rd_a(rd_a[b]),
			.rd_b(rd_b[b])
		);
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			push_job.col_a[k] = rd_a[s1_sel_s1[k]];
			push_job.col_b[k] = rd_b[s1_sel_s1[k]];
		end
		push_job.first     = s1_first_s1;
		push_job.frame_end = s1_last_s1;
		push_job.four_ch   = s1_fc_s1;
	end

endmodule

/* hw/rtl/c3rb_queue.sv */
// Short job queue between the front and the filter back end.
// Depends on c3rb_pkg for the job type and depth.
module c3rb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  c3rb_pkg::job_t push_job,
	input  logic           pop,
	output c3rb_pkg::job_t head,
	output logic           empty,
	output logic           full
);
	import c3rb_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t          mem [QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign head  = mem[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/c3rb_back.sv */
// Back end: window columns, 36 tap products, sums with clamp, output register.
// Depends on c3rb_pkg for the job type and the saturating helper.
module c3rb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  c3rb_pkg::cfg_t cfg,
	input  c3rb_pkg::job_t head,
	input  logic           empty,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [31:0]    out_data,
	output logic           out_last
);
	import c3rb_pkg::*;

	logic                    en;
	logic [2:0][31:0]        win_l, win_m, win_r;
	logic [2:0][31:0]        wm_q, wr_q;
	logic [7:0]              tap [4][9];
	logic signed [15:0]      coef [9];
	logic signed [PROD_W-1:0] prod [4][9];
	logic signed [PROD_W-1:0] prod_s1 [4][9];
	logic                    v_s1, last_s1, fc_s1;
	logic signed [SUM_W-1:0] sum [4];
	logic [31:0]             res;
	logic                    out_v_q;

	assign en        = !out_v_q || out_ready;
	assign pop       = en && !empty;
	assign out_valid = out_v_q;

	always_comb begin
		// a new row repeats column 0 on the left
		for (int k = 0; k < 3; k++) begin
			win_l[k] = head.first ? head.col_b[k] : wm_q[k];
			win_m[k] = head.first ? head.col_b[k] : wr_q[k];
			win_r[k] = head.col_a[k];
		end
		for (int i = 0; i < 9; i++) begin
			coef[i] = $signed(cfg.kernel[i / 3][16 * (i % 3) +: 16]);
			for (int ch = 0; ch < 4; ch++) begin
				case (i % 3)
					0:       tap[ch][i] = win_l[i / 3][8 * ch +: 8];
					1:       tap[ch][i] = win_m[i / 3][8 * ch +: 8];
					default: tap[ch][i] = win_r[i / 3][8 * ch +: 8];
				endcase
				prod[ch][i] = PROD_W'($signed({1'b0, tap[ch][i]}) * coef[i]);
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < 4; ch++) begin
			sum[ch] = '0;
			for (int i = 0; i < 9; i++) begin
				sum[ch] = sum[ch] + SUM_W'(prod_s1[ch][i]);
			end
			res[8 * ch +: 8] = sat_q8(sum[ch]);
		end
		if (!fc_s1) begin
			res[31:24] = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wm_q    <= '0;
			wr_q    <= '0;
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pop) begin
				wm_q <= win_m;
				wr_q <= win_r;
			end
			if (en) begin
				v_s1    <= !empty;
				out_v_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1  <= prod;
			last_s1  <= head.frame_end;
			fc_s1    <= head.four_ch;
			out_data <= res;
			out_last <= last_s1;
		end
	end

endmodule
